// ===== src/fou_pkg.sv =====
`default_nettype none
package fou_pkg;

	localparam int OCC_W        = 128;
	localparam int WORD_W       = 64;
	localparam int DIGIT_W      = 32;
	localparam int DIGIT_LW     = $clog2(DIGIT_W);
	localparam int NUM_DIGITS   = OCC_W / DIGIT_W;
	localparam int CNT_W        = $clog2(NUM_DIGITS);
	localparam int ORB_W        = 7;
	localparam int SIGN_W       = 2;
	localparam int NUM_ORBITALS = 128;

	localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
	localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
	localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

	typedef enum logic [2:0] {
		CMD_RESET      = 3'd0,
		CMD_CLEAR_SET  = 3'd1,
		CMD_SET        = 3'd2,
		CMD_CREATE     = 3'd3,
		CMD_ANNIHILATE = 3'd4,
		CMD_OVERLAP    = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		OCC_KEEP,
		OCC_CLEAR,
		OCC_CLEAR_SET,
		OCC_SET,
		OCC_TOGGLE
	} occ_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic             load;
		logic             shift;
		logic             last;
		logic [CNT_W-1:0] digit;
		logic [ORB_W-1:0] orbital;
		occ_op_t          op;
	} scan_ctl_t;

	typedef struct packed {
		logic parity;
		logic occupied;
		logic equal;
	} scan_stat_t;

endpackage
`default_nettype wire

// ===== src/fou_digit_scan.sv =====
`default_nettype none
module fou_digit_scan
	import fou_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  scan_ctl_t             ctl,
	input  logic [WORD_W-1:0]     other_low,
	input  logic [WORD_W-1:0]     other_high,
	output scan_stat_t            stat,
	output logic [OCC_W-1:0]      occ
);

	logic [OCC_W-1:0]       occ_q;
	logic [OCC_W-1:0]       other_q;
	logic                   par_q;
	logic                   hit_q;
	logic                   eq_q;

	logic [DIGIT_W-1:0]     digit;
	logic [DIGIT_W-1:0]     other_digit;
	logic [DIGIT_W-1:0]     below_mask;
	logic [DIGIT_LW-1:0]    pos;
	logic [CNT_W-1:0]       pd;
	logic                   d_par;
	logic                   d_hit;
	logic                   d_eq;
	logic [OCC_W-1:0]       rot;
	logic [OCC_W-1:0]       onehot;
	logic [OCC_W-1:0]       occ_next;

	assign digit       = occ_q[DIGIT_W-1:0];
	assign other_digit = other_q[DIGIT_W-1:0];
	assign pos         = ctl.orbital[DIGIT_LW-1:0];
	assign pd          = ctl.orbital[ORB_W-1:DIGIT_LW];
	assign below_mask  = ~({DIGIT_W{1'b1}} << pos);
	assign d_eq        = (digit == other_digit);

	// Parity of occupied orbitals below the target and its own bit, one digit per cycle
	always_comb begin
		d_par = 1'b0;
		d_hit = 1'b0;
		if (ctl.digit < pd) begin
			d_par = ^digit;
		end else if (ctl.digit == pd) begin
			d_par = ^(digit & below_mask);
			d_hit = digit[pos];
		end
	end

	assign stat.parity   = par_q ^ d_par;
	assign stat.occupied = hit_q | d_hit;
	assign stat.equal    = eq_q & d_eq;

	assign rot    = {occ_q[DIGIT_W-1:0], occ_q[OCC_W-1:DIGIT_W]};
	assign onehot = {{(OCC_W-1){1'b0}}, 1'b1} << ctl.orbital;

	always_comb begin
		unique case (ctl.op)
			OCC_CLEAR:     occ_next = '0;
			OCC_CLEAR_SET: occ_next = onehot;
			OCC_SET:       occ_next = rot | onehot;
			OCC_TOGGLE:    occ_next = rot ^ onehot;
			default:       occ_next = rot;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (ctl.last) begin
			occ_q <= occ_next;
		end else if (ctl.shift) begin
			occ_q <= rot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_q <= 1'b0;
			hit_q <= 1'b0;
			eq_q  <= 1'b1;
		end else if (ctl.load) begin
			par_q <= 1'b0;
			hit_q <= 1'b0;
			eq_q  <= 1'b1;
		end else if (ctl.shift) begin
			par_q <= stat.parity;
			hit_q <= stat.occupied;
			eq_q  <= stat.equal;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			other_q <= {other_high, other_low};
		end else if (ctl.shift) begin
			other_q <= {other_q[DIGIT_W-1:0], other_q[OCC_W-1:DIGIT_W]};
		end
	end

	assign occ = occ_q;

endmodule
`default_nettype wire

// ===== src/fou_ctrl.sv =====
`default_nettype none
module fou_ctrl
	import fou_pkg::*;
#(
	parameter int NUM_ORB = NUM_ORBITALS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [2:0]         cmd,
	input  logic [ORB_W-1:0]   orbital,
	input  logic [SIGN_W-1:0]  other_sign,
	input  scan_stat_t         stat,
	output scan_ctl_t          ctl,
	output logic               busy,
	output logic               done,
	output logic [SIGN_W-1:0]  sign,
	output logic [SIGN_W-1:0]  overlap
);

	localparam logic [ORB_W:0] ORB_LIMIT = (ORB_W + 1)'(NUM_ORB);

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     cnt_q;
	cmd_t                 cmd_q;
	logic [ORB_W-1:0]     orbital_q;
	logic [SIGN_W-1:0]    osign_q;
	logic [SIGN_W-1:0]    sign_q, sign_d;
	logic [SIGN_W-1:0]    ov_q, ov_d;
	logic                 done_q;
	logic                 in_range;
	logic                 accept;
	logic                 last;
	logic                 creating;
	occ_op_t              op;

	assign in_range = ({1'b0, orbital_q} < ORB_LIMIT);
	assign accept   = start && (state_q == ST_IDLE);
	assign last     = (state_q == ST_SCAN) && (cnt_q == CNT_W'(NUM_DIGITS - 1));
	assign creating = (cmd_q == CMD_CREATE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_SCAN;
			ST_SCAN: if (last) state_d = ST_IDLE;
		endcase
	end

	// Decide the occupancy update, the new sign and the overlap from the finished scan
	always_comb begin
		op     = OCC_KEEP;
		sign_d = sign_q;
		ov_d   = SIGN_ZERO;
		unique case (cmd_q)
			CMD_RESET: begin
				op     = OCC_CLEAR;
				sign_d = SIGN_POS;
			end
			CMD_CLEAR_SET: begin
				op     = in_range ? OCC_CLEAR_SET : OCC_CLEAR;
				sign_d = SIGN_POS;
			end
			CMD_SET: begin
				op = in_range ? OCC_SET : OCC_KEEP;
			end
			CMD_CREATE, CMD_ANNIHILATE: begin
				if (sign_q != SIGN_ZERO && in_range) begin
					if (stat.occupied == creating) begin
						sign_d = SIGN_ZERO;
					end else begin
						op = OCC_TOGGLE;
						if (stat.parity) sign_d = {~sign_q[1], sign_q[0]};
					end
				end
			end
			CMD_OVERLAP: begin
				if (sign_q != SIGN_ZERO && osign_q != SIGN_ZERO && stat.equal)
					ov_d = (sign_q[1] ^ osign_q[1]) ? SIGN_NEG : SIGN_POS;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			sign_q  <= SIGN_POS;
			ov_q    <= SIGN_ZERO;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= last;
			if (accept) cnt_q <= '0;
			else if (state_q == ST_SCAN) cnt_q <= cnt_q + 1'b1;
			if (last) begin
				sign_q <= sign_d;
				ov_q   <= ov_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd_t'(cmd);
			orbital_q <= orbital;
			osign_q   <= other_sign;
		end
	end

	assign ctl.load    = accept;
	assign ctl.shift   = (state_q == ST_SCAN);
	assign ctl.last    = last;
	assign ctl.digit   = cnt_q;
	assign ctl.orbital = orbital_q;
	assign ctl.op      = op;

	assign busy    = (state_q != ST_IDLE);
	assign done    = done_q;
	assign sign    = sign_q;
	assign overlap = ov_q;

endmodule
`default_nettype wire

// ===== src/fermion_occupation_operator_unit.sv =====
// Result: an accepted request steps through ST_SCAN, and done, registered from
//   the last step, marks its result. A new request is accepted only when idle;
//   the 128-bit occupation vector is scanned 32 bits per cycle for the parity
//   below the orbital and the overlap compare.
// Reset: arst_n clears the occupation vector and sets the sign to +1; done must be
//   taken in its cycle, as the receiver cannot stall the unit.
`default_nettype none
module fermion_occupation_operator_unit
	import fou_pkg::*;
#(
	parameter int NUM_ORB = NUM_ORBITALS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         cmd,
	input  logic [ORB_W-1:0]   orbital,
	input  logic [WORD_W-1:0]  other_low,
	input  logic [WORD_W-1:0]  other_high,
	input  logic [SIGN_W-1:0]  other_sign,
	output logic               done,
	output logic [SIGN_W-1:0]  sign,
	output logic [WORD_W-1:0]  occ_low,
	output logic [WORD_W-1:0]  occ_high,
	output logic [SIGN_W-1:0]  overlap
);

	scan_ctl_t          ctl;
	scan_stat_t         stat;
	logic [OCC_W-1:0]   occ;

	// Sequencer: hold the request, step the digit count, commit sign and overlap
	fou_ctrl #(
		.NUM_ORB (NUM_ORB)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cmd        (cmd),
		.orbital    (orbital),
		.other_sign (other_sign),
		.stat       (stat),
		.ctl        (ctl),
		.busy       (busy),
		.done       (done),
		.sign       (sign),
		.overlap    (overlap)
	);

	// Datapath: rotate the occupation vector one digit a cycle; it is back in
	// place on the last step, where the bit update is applied
	fou_digit_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.other_low  (other_low),
		.other_high (other_high),
		.stat       (stat),
		.occ        (occ)
	);

	// Outside a scan the vector sits unrotated, so the result reads it directly
	assign occ_low  = occ[WORD_W-1:0];
	assign occ_high = occ[OCC_W-1:WORD_W];

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while scan still running");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe repeated");

	a_sign_code: assert property (@(posedge clk) disable iff (!arst_n)
		(sign != 2'b10) && (overlap != 2'b10))
		else $error("illegal sign encoding");

endmodule
`default_nettype wire

// ===== bench/tb_fermion_occupation_operator_unit.sv =====
`timescale 1ns / 1ps
module tb_fermion_occupation_operator_unit;
	import fou_pkg::*;

	// Spare command codes: the unit must leave the determinant alone for these
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	localparam logic [WORD_W-1:0] TOP_BIT  = 64'h8000_0000_0000_0000;
	localparam logic [WORD_W-1:0] ALL_ONES = '1;
	localparam logic [SIGN_W-1:0] SIGN_MINUS_TWO = 2'b10;

	localparam int RANDOM_REQUESTS = 1300;
	localparam int PAUSE_AT        = 650;

	// One request to the unit, plus an optional hand-written expectation
	typedef struct {
		logic [2:0]        op;
		logic [ORB_W-1:0]  orb;
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] hi;
		logic [SIGN_W-1:0] os;
		bit                typed;
		logic [SIGN_W-1:0] want_sign;
		logic [WORD_W-1:0] want_low;
		logic [WORD_W-1:0] want_high;
		logic [SIGN_W-1:0] want_overlap;
	} request_t;

	typedef struct {
		logic [SIGN_W-1:0] sign;
		logic [WORD_W-1:0] occ_low;
		logic [WORD_W-1:0] occ_high;
		logic [SIGN_W-1:0] overlap;
	} det_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [2:0]        cmd = '0;
	logic [ORB_W-1:0]  orbital = '0;
	logic [WORD_W-1:0] other_low = '0;
	logic [WORD_W-1:0] other_high = '0;
	logic [SIGN_W-1:0] other_sign = '0;
	logic              done;
	logic [SIGN_W-1:0] sign;
	logic [WORD_W-1:0] occ_low;
	logic [WORD_W-1:0] occ_high;
	logic [SIGN_W-1:0] overlap;

	// Shadow copy of the determinant, advanced at each accepted request
	logic [OCC_W-1:0]  det_occ = '0;
	logic [SIGN_W-1:0] det_sign = SIGN_POS;

	det_result_t pending_results[$];
	request_t    directed_rows[$];
	int          mismatches = 0;
	int          burst_left = 0;

	fermion_occupation_operator_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.orbital    (orbital),
		.other_low  (other_low),
		.other_high (other_high),
		.other_sign (other_sign),
		.done       (done),
		.sign       (sign),
		.occ_low    (occ_low),
		.occ_high   (occ_high),
		.overlap    (overlap)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Hard stop: far beyond the slowest correct run
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic report(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		$display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Work out the determinant after one request, and the result it reports.
	// Overlap is zero for everything but the overlap command.
	function automatic det_result_t apply_to_determinant(input request_t r);
		det_result_t res;
		logic [SIGN_W-1:0] theirs;
		logic creating;
		logic occupied;
		logic below;
		// Pattern minus two counts as a negative sign
		theirs = (r.os == SIGN_ZERO) ? SIGN_ZERO : ((r.os == SIGN_POS) ? SIGN_POS : SIGN_NEG);
		res.overlap = SIGN_ZERO;
		unique case (r.op)
			CMD_RESET: begin
				det_occ  = '0;
				det_sign = SIGN_POS;
			end
			CMD_CLEAR_SET: begin
				det_occ          = '0;
				det_occ[r.orb]   = 1'b1;
				det_sign         = SIGN_POS;
			end
			CMD_SET: det_occ[r.orb] = 1'b1;
			CMD_CREATE, CMD_ANNIHILATE: begin
				creating = (r.op == CMD_CREATE);
				occupied = det_occ[r.orb];
				// Null state swallows both operators
				if (det_sign != SIGN_ZERO) begin
					if (occupied == creating) begin
						// Pauli rule broken: collapse to null, keep the bits
						det_sign = SIGN_ZERO;
					end else begin
						below = ^(det_occ & ((128'd1 << r.orb) - 128'd1));
						det_occ[r.orb] = creating;
						if (below)
							det_sign = (det_sign == SIGN_POS) ? SIGN_NEG : SIGN_POS;
					end
				end
			end
			CMD_OVERLAP: begin
				if (det_sign != SIGN_ZERO && theirs != SIGN_ZERO && det_occ == {r.hi, r.lo})
					res.overlap = (det_sign == theirs) ? SIGN_POS : SIGN_NEG;
			end
			default: ;
		endcase
		res.sign     = det_sign;
		res.occ_low  = det_occ[WORD_W-1:0];
		res.occ_high = det_occ[OCC_W-1:WORD_W];
		return res;
	endfunction

	function automatic request_t mk(input logic [2:0] op, input logic [ORB_W-1:0] orb,
			input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] hi,
			input logic [SIGN_W-1:0] os, input bit typed,
			input logic [SIGN_W-1:0] ws, input logic [WORD_W-1:0] wl,
			input logic [WORD_W-1:0] wh, input logic [SIGN_W-1:0] wo);
		request_t r;
		r.op = op;  r.orb = orb;  r.lo = lo;  r.hi = hi;  r.os = os;
		r.typed = typed;
		r.want_sign = ws;  r.want_low = wl;  r.want_high = wh;  r.want_overlap = wo;
		return r;
	endfunction

	// Find an orbital that is (or is not) occupied, starting at a random place
	function automatic logic [ORB_W-1:0] pick_orbital(input logic want_occupied);
		logic [ORB_W-1:0] first;
		logic [ORB_W-1:0] idx;
		first = ORB_W'($urandom_range(0, NUM_ORBITALS - 1));
		for (int i = 0; i < NUM_ORBITALS; i++) begin
			idx = first + ORB_W'(i);
			if (det_occ[idx] == want_occupied)
				return idx;
		end
		return first;
	endfunction

	// Sender idling: bursts of back-to-back requests split by random gaps
	function automatic int unsigned next_gap();
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 20);
			return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
		end
		burst_left--;
		return 0;
	endfunction

	// Drive one request and hold it until the unit takes it, then log its result
	task automatic send_request(input request_t r, input int unsigned gap);
		det_result_t res;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd        <= r.op;
		orbital    <= r.orb;
		other_low  <= r.lo;
		other_high <= r.hi;
		other_sign <= r.os;
		start      <= 1'b1;
		do @(posedge clk); while (busy);
		res = apply_to_determinant(r);
		// Hand-written rows stand in for the shadow model's answer
		if (r.typed) begin
			res.sign     = r.want_sign;
			res.occ_low  = r.want_low;
			res.occ_high = r.want_high;
			res.overlap  = r.want_overlap;
		end
		pending_results.push_back(res);
	endtask

	function automatic request_t random_request();
		request_t r;
		int unsigned pick;
		r = mk(CMD_RESET, ORB_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
			SIGN_W'($urandom), 1'b0, '0, '0, '0, '0);
		pick = $urandom_range(0, 99);
		// Climb out of the null state most of the time, else it sticks
		if (det_sign == SIGN_ZERO && pick < 60)
			r.op = pick[0] ? CMD_RESET : CMD_CLEAR_SET;
		else if (pick < 4)
			r.op = CMD_RESET;
		else if (pick < 10)
			r.op = CMD_CLEAR_SET;
		else if (pick < 18)
			r.op = CMD_SET;
		else if (pick < 50)
			r.op = CMD_CREATE;
		else if (pick < 80)
			r.op = CMD_ANNIHILATE;
		else if (pick < 96)
			r.op = CMD_OVERLAP;
		else
			r.op = pick[0] ? CMD_SPARE_7 : CMD_SPARE_6;

		// Mostly legal operators, so the sign survives and parity gets exercised
		if (r.op == CMD_CREATE && $urandom_range(0, 3) != 0)
			r.orb = pick_orbital(1'b0);
		else if (r.op == CMD_ANNIHILATE && $urandom_range(0, 3) != 0)
			r.orb = pick_orbital(1'b1);

		// Overlap: match the state often, miss by one bit sometimes
		if (r.op == CMD_OVERLAP) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				r.lo = det_occ[WORD_W-1:0];
				r.hi = det_occ[OCC_W-1:WORD_W];
				if (pick >= 60) begin
					if (pick[0])
						r.lo[$urandom_range(0, WORD_W - 1)] ^= 1'b1;
					else
						r.hi[$urandom_range(0, WORD_W - 1)] ^= 1'b1;
				end
			end
		end
		return r;
	endfunction

	// Result checker: the receiver cannot stall, so take every done pulse
	always @(posedge clk) begin : check_results
		det_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report("unexpected result", {occ_high[0], occ_low[62:0]}, '0);
			end else begin
				want = pending_results.pop_front();
				if (sign !== want.sign)
					report("sign", WORD_W'(sign), WORD_W'(want.sign));
				if (occ_low !== want.occ_low)
					report("occ_low", occ_low, want.occ_low);
				if (occ_high !== want.occ_high)
					report("occ_high", occ_high, want.occ_high);
				if (overlap !== want.overlap)
					report("overlap", WORD_W'(overlap), WORD_W'(want.overlap));
			end
		end
	end

	initial begin
		// Directed rows: typed rows carry a result readable at a glance
		directed_rows.push_back(mk(CMD_OVERLAP, 7'd0, '0, '0, SIGN_POS,
			1'b1, SIGN_POS, '0, '0, SIGN_POS));
		directed_rows.push_back(mk(CMD_CREATE, 7'd0, '0, '0, SIGN_ZERO,
			1'b1, SIGN_POS, 64'd1, '0, SIGN_ZERO));
		// Odd count below the top orbital: flip the sign
		directed_rows.push_back(mk(CMD_CREATE, 7'd127, ALL_ONES, ALL_ONES, SIGN_NEG,
			1'b1, SIGN_NEG, 64'd1, TOP_BIT, SIGN_ZERO));
		directed_rows.push_back(mk(CMD_OVERLAP, 7'd127, 64'd1, TOP_BIT, SIGN_POS,
			1'b1, SIGN_NEG, 64'd1, TOP_BIT, SIGN_NEG));
		directed_rows.push_back(mk(CMD_OVERLAP, 7'd0, 64'd1, TOP_BIT, SIGN_MINUS_TWO,
			1'b1, SIGN_NEG, 64'd1, TOP_BIT, SIGN_POS));
		directed_rows.push_back(mk(CMD_OVERLAP, 7'd0, 64'd1, TOP_BIT, SIGN_ZERO,
			1'b1, SIGN_NEG, 64'd1, TOP_BIT, SIGN_ZERO));
		directed_rows.push_back(mk(CMD_OVERLAP, 7'd5, ALL_ONES, TOP_BIT, SIGN_POS,
			1'b0, '0, '0, '0, '0));
		// Pauli rule broken: collapse to the null state
		directed_rows.push_back(mk(CMD_CREATE, 7'd0, '0, '0, SIGN_POS,
			1'b1, SIGN_ZERO, 64'd1, TOP_BIT, SIGN_ZERO));
		directed_rows.push_back(mk(CMD_ANNIHILATE, 7'd127, '0, '0, SIGN_POS,
			1'b0, '0, '0, '0, '0));
		directed_rows.push_back(mk(CMD_OVERLAP, 7'd0, 64'd1, TOP_BIT, SIGN_NEG,
			1'b0, '0, '0, '0, '0));
		directed_rows.push_back(mk(CMD_SET, 7'd64, '0, '0, SIGN_ZERO,
			1'b0, '0, '0, '0, '0));
		directed_rows.push_back(mk(CMD_RESET, 7'd127, ALL_ONES, ALL_ONES, SIGN_POS,
			1'b1, SIGN_POS, '0, '0, SIGN_ZERO));
		directed_rows.push_back(mk(CMD_CLEAR_SET, 7'd127, '0, '0, SIGN_ZERO,
			1'b1, SIGN_POS, '0, TOP_BIT, SIGN_ZERO));
		directed_rows.push_back(mk(CMD_ANNIHILATE, 7'd127, '0, '0, SIGN_ZERO,
			1'b1, SIGN_POS, '0, '0, SIGN_ZERO));
		// Annihilate on an empty orbital breaks the Pauli rule too
		directed_rows.push_back(mk(CMD_ANNIHILATE, 7'd3, '0, '0, SIGN_ZERO,
			1'b1, SIGN_ZERO, '0, '0, SIGN_ZERO));
		directed_rows.push_back(mk(CMD_CLEAR_SET, 7'd63, '0, '0, SIGN_ZERO,
			1'b1, SIGN_POS, TOP_BIT, '0, SIGN_ZERO));
		// Word boundary: the count below crosses from the low word
		directed_rows.push_back(mk(CMD_CREATE, 7'd64, '0, '0, SIGN_ZERO,
			1'b0, '0, '0, '0, '0));
		directed_rows.push_back(mk(CMD_CREATE, 7'd65, '0, '0, SIGN_ZERO,
			1'b0, '0, '0, '0, '0));
		directed_rows.push_back(mk(CMD_SPARE_6, 7'd1, ALL_ONES, ALL_ONES, SIGN_POS,
			1'b0, '0, '0, '0, '0));
		directed_rows.push_back(mk(CMD_SPARE_7, 7'd2, TOP_BIT, 64'd3, SIGN_NEG,
			1'b0, '0, '0, '0, '0));
		directed_rows.push_back(mk(CMD_SET, 7'd0, '0, '0, SIGN_ZERO,
			1'b0, '0, '0, '0, '0));
		directed_rows.push_back(mk(CMD_OVERLAP, 7'd0, 64'h8000_0000_0000_0001, 64'd3,
			SIGN_NEG, 1'b0, '0, '0, '0, '0));
		directed_rows.push_back(mk(CMD_ANNIHILATE, 7'd64, '0, '0, SIGN_ZERO,
			1'b0, '0, '0, '0, '0));
		directed_rows.push_back(mk(CMD_OVERLAP, 7'd0, ALL_ONES, ALL_ONES, SIGN_POS,
			1'b0, '0, '0, '0, '0));

		// Hold reset, then release it once
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i], next_gap());

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			// Drain halfway through: the unit must go fully idle and pick up again
			if (i == PAUSE_AT) begin
				start <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
				@(posedge clk);
			end
			send_request(random_request(), next_gap());
		end

		// Drop start and wait for the tail of results, then idle before the verdict
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
